/* sv/adc_temperature_digit_display_defines.svh */
`ifndef ADC_TEMPERATURE_DIGIT_DISPLAY_DEFINES_SVH
`define ADC_TEMPERATURE_DIGIT_DISPLAY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is held.
`define ATDD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atdd assertion failed");

// Next-cycle implication, sampled on clk, off while reset is held.
`define ATDD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atdd assertion failed");

`endif

/* sv/atdd_pkg.sv */
package atdd_pkg;

  localparam int SampleW = 10;
  localparam int ScaleW  = 8;
  localparam int ProdW   = SampleW + ScaleW;
  localparam int ValW    = 8;
  localparam int AddrW   = 4;
  localparam int DigitW  = 4;
  localparam int CfgW    = 8;
  localparam int CfgIdxW = 2;
  localparam int SampleMax = 1023;
  localparam int QDepth  = 2;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FULL_SCALE = 2'd0,
    CFG_ONES_ADDR  = 2'd1,
    CFG_TENS_ADDR  = 2'd2,
    CFG_HUND_ADDR  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic            vld;
    logic [ValW-1:0] val;
  } val_xfer_t;

  typedef struct packed {
    logic [DigitW-1:0] hund;
    logic [DigitW-1:0] tens;
    logic [DigitW-1:0] ones;
  } digits_t;

  // Split 0..255 into decimal digits; tens uses x*205>>11, exact below 1029.
  function automatic digits_t to_digits(input logic [ValW-1:0] v);
    digits_t     d;
    logic [6:0]  rem;
    logic [14:0] tprod;
    logic [6:0]  tens10;
    if (v >= 8'd200) begin
      d.hund = 4'd2;
      rem    = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      d.hund = 4'd1;
      rem    = 7'(v - 8'd100);
    end else begin
      d.hund = 4'd0;
      rem    = v[6:0];
    end
    tprod  = 15'(rem) * 15'd205;
    d.tens = tprod[14:11];
    tens10 = 7'(d.tens) * 7'd10;
    d.ones = 4'(rem - tens10);
    return d;
  endfunction

endpackage

/* sv/atdd_front.sv */
module atdd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [atdd_pkg::SampleW-1:0] in_sample,
  output logic                        in_stall,
  input  logic [atdd_pkg::ScaleW-1:0]  full_scale,
  input  logic                        q_full,
  output atdd_pkg::val_xfer_t          push
);
  import atdd_pkg::*;

  logic             prod_vld_r, prod_vld_nxt;
  logic [ProdW-1:0] prod_r;
  logic [ValW-1:0]  shown_r;
  logic             seen_r;
  logic             accept, drain, changed, ge;
  logic [ValW-1:0]  q0, val;
  logic [SampleW:0] rem;

  assign in_stall = prod_vld_r & q_full;
  assign accept   = in_valid & ~in_stall;
  assign drain    = prod_vld_r & ~q_full;

  // Divide by 1023: q0 = p>>10, remainder (p mod 1024)+q0 stays below 2*1023.
  assign q0  = prod_r[ProdW-1:SampleW];
  assign rem = {1'b0, prod_r[SampleW-1:0]} + (SampleW+1)'(q0);
  assign ge  = rem >= (SampleW+1)'(SampleMax);
  assign val = q0 + ValW'(ge);

  assign changed  = ~seen_r | (val != shown_r);
  assign push.vld = drain & changed;
  assign push.val = val;

  assign prod_vld_nxt = accept | (prod_vld_r & q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      seen_r     <= 1'b0;
      shown_r    <= '0;
    end else begin
      prod_vld_r <= prod_vld_nxt;
      if (push.vld) begin
        seen_r  <= 1'b1;
        shown_r <= val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= ProdW'(in_sample) * ProdW'(full_scale);
    end
  end

endmodule

/* sv/atdd_fifo.sv */
module atdd_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  atdd_pkg::val_xfer_t        push,
  input  logic                      pop,
  output logic                      full,
  output logic                      not_empty,
  output logic [atdd_pkg::ValW-1:0] rd_val
);
  import atdd_pkg::*;

  logic [ValW-1:0]  mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = cnt_r == QCntW'(QDepth);
  assign not_empty = cnt_r != '0;
  assign rd_val    = mem_r[rd_ptr_r];
  assign do_push   = push.vld & ~full;
  assign do_pop    = pop & not_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.val;
    end
  end

endmodule

/* sv/atdd_back.sv */
module atdd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_vld,
  input  logic [atdd_pkg::ValW-1:0]    q_val,
  output logic                         pop,
  input  logic [atdd_pkg::AddrW-1:0]   ones_addr,
  input  logic [atdd_pkg::AddrW-1:0]   tens_addr,
  input  logic [atdd_pkg::AddrW-1:0]   hund_addr,
  output logic                         out_valid,
  output logic [atdd_pkg::AddrW-1:0]   out_reg_addr,
  output logic [atdd_pkg::DigitW-1:0]  out_digit,
  output logic                         out_last,
  input  logic                         out_stall
);
  import atdd_pkg::*;

  typedef enum logic [2:0] {
    ST_HUND = 3'b001,
    ST_TENS = 3'b010,
    ST_ONES = 3'b100
  } step_t;

  step_t             step_r, step_nxt;
  logic              busy_r, busy_nxt;
  digits_t           dig_r;
  logic              out_valid_r;
  logic [AddrW-1:0]  out_addr_r;
  logic [DigitW-1:0] out_digit_r;
  logic              out_last_r;
  logic              slot_free, load, at_ones;
  logic [AddrW-1:0]  sel_addr;
  logic [DigitW-1:0] sel_digit;

  assign slot_free = ~out_valid_r | ~out_stall;
  assign load      = busy_r & slot_free;
  assign at_ones   = step_r == ST_ONES;
  assign pop       = q_vld & (~busy_r | (load & at_ones));

  always_comb begin
    unique case (step_r)
      ST_HUND: begin
        sel_addr  = hund_addr;
        sel_digit = dig_r.hund;
        step_nxt  = ST_TENS;
      end
      ST_TENS: begin
        sel_addr  = tens_addr;
        sel_digit = dig_r.tens;
        step_nxt  = ST_ONES;
      end
      ST_ONES: begin
        sel_addr  = ones_addr;
        sel_digit = dig_r.ones;
        step_nxt  = ST_HUND;
      end
      default: begin
        sel_addr  = ones_addr;
        sel_digit = dig_r.ones;
        step_nxt  = ST_HUND;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    if (pop) begin
      busy_nxt = 1'b1;
    end else if (load && at_ones) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= ST_HUND;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (pop) begin
        step_r <= ST_HUND;
      end else if (load) begin
        step_r <= step_nxt;
      end
      // Refill the output slot in the cycle it drains.
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dig_r <= to_digits(q_val);
    end
    if (load) begin
      out_addr_r  <= sel_addr;
      out_digit_r <= sel_digit;
      out_last_r  <= at_ones;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_reg_addr = out_addr_r;
  assign out_digit    = out_digit_r;
  assign out_last     = out_last_r;

endmodule

/* sv/adc_temperature_digit_display.sv */
// Channel | Ports                                         | Transfer when
// in      | in_valid, in_stall, in_sample                 | in_valid & !in_stall
// out     | out_valid, out_stall, out_reg_addr/digit/last | out_valid & !out_stall
// cfg     | cfg_we, cfg_index, cfg_wdata                  | cfg_we
//
// A sample is taken every cycle while the two-entry value queue has room.
// A changed value produces three display writes, one per cycle unless
// out_stall holds them, set by the single output register, after the
// product, queue and digit registers; unchanged samples give no output.
// Synchronous reset restores default registers and forgets the shown value.
// out_stall holds the output; a full queue with a held product raises in_stall.
module adc_temperature_digit_display (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [atdd_pkg::SampleW-1:0]  in_sample,
  output logic                          in_stall,
  output logic                          out_valid,
  output logic [atdd_pkg::AddrW-1:0]    out_reg_addr,
  output logic [atdd_pkg::DigitW-1:0]   out_digit,
  output logic                          out_last,
  input  logic                          out_stall,
  input  logic                          cfg_we,
  input  logic [atdd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [atdd_pkg::CfgW-1:0]     cfg_wdata
);
  import atdd_pkg::*;

  logic [ScaleW-1:0] full_scale_r;
  logic [AddrW-1:0]  ones_addr_r, tens_addr_r, hund_addr_r;
  val_xfer_t         push;
  logic              q_full, q_vld, pop;
  logic [ValW-1:0]   q_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= ScaleW'(150);
      ones_addr_r  <= AddrW'(1);
      tens_addr_r  <= AddrW'(2);
      hund_addr_r  <= AddrW'(3);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FULL_SCALE: full_scale_r <= cfg_wdata[ScaleW-1:0];
        CFG_ONES_ADDR:  ones_addr_r  <= cfg_wdata[AddrW-1:0];
        CFG_TENS_ADDR:  tens_addr_r  <= cfg_wdata[AddrW-1:0];
        CFG_HUND_ADDR:  hund_addr_r  <= cfg_wdata[AddrW-1:0];
        default: ;
      endcase
    end
  end

  atdd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_sample  (in_sample),
    .in_stall   (in_stall),
    .full_scale (full_scale_r),
    .q_full     (q_full),
    .push       (push)
  );

  atdd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_vld),
    .rd_val    (q_val)
  );

  atdd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_vld        (q_vld),
    .q_val        (q_val),
    .pop          (pop),
    .ones_addr    (ones_addr_r),
    .tens_addr    (tens_addr_r),
    .hund_addr    (hund_addr_r),
    .out_valid    (out_valid),
    .out_reg_addr (out_reg_addr),
    .out_digit    (out_digit),
    .out_last     (out_last),
    .out_stall    (out_stall)
  );

endmodule

/* sv/atdd_checker.sv */
`include "adc_temperature_digit_display_defines.svh"

module atdd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic [atdd_pkg::AddrW-1:0]    out_reg_addr,
  input logic [atdd_pkg::DigitW-1:0]   out_digit,
  input logic                          out_last,
  input logic                          out_stall
);
  import atdd_pkg::*;

  // A run of three writes goes out without gaps once started.
  `ATDD_ASSERT_NXT(a_run_unbroken, out_valid && !out_stall && !out_last, out_valid)
  // Every digit is decimal.
  `ATDD_ASSERT_IMP(a_digit_decimal, out_valid, out_digit <= 4'd9)
  // A held write keeps its payload.
  `ATDD_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_reg_addr) && $stable(out_digit) && $stable(out_last))

endmodule

bind adc_temperature_digit_display atdd_checker u_atdd_checker (.*);
